// ----- design/mtg_pkg.sv -----
// Shared types, constants and the tempering function for the MT19937 generator.
// No dependencies.
package mtg_pkg;

    localparam int unsigned IDX_W = 10;
    localparam logic [IDX_W-1:0] N_WORDS    = 10'd624;
    localparam logic [IDX_W-1:0] LAST_WORD  = 10'd623;
    localparam logic [IDX_W-1:0] TWIST_OFF  = 10'd397;
    localparam logic [IDX_W-1:0] TWIST_WRAP = 10'd227;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] SEED_MULT    = 32'd1812433253;
    localparam logic [31:0] RESET_SEED   = 32'd5489;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    localparam logic [1:0] REQ_RAW   = 2'd0;
    localparam logic [1:0] REQ_SHIFT = 2'd1;
    localparam logic [1:0] REQ_MOD   = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef enum logic [1:0] {
        K_RAW,
        K_SHIFT,
        K_MOD,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] bound;
    } t_req;

    typedef struct packed {
        logic [31:0] value;
        logic        bad;
    } t_res;

    typedef enum logic [2:0] {
        S_SEED,
        S_IDLE,
        S_TW_A,
        S_TW_B,
        S_TW_C,
        S_DRAW_A,
        S_DRAW_B,
        S_DIV
    } t_core_state;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

// ----- design/mtg_front.sv -----
// Request front end: classifies requests and holds them in a two-entry queue.
// Depends on mtg_pkg.
module mtg_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [1:0]          i_req_type,
    input  logic [30:0]         i_bound,
    output logic                o_full,
    output logic                o_valid,
    output mtg_pkg::t_req       o_req,
    input  logic                i_pop
);

    mtg_pkg::t_req r_q [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    mtg_pkg::t_req n_entry;
    logic          push_ok;
    logic          pop_ok;

    always_comb begin
        n_entry.bound = i_bound;
        case (i_req_type)
            mtg_pkg::REQ_SHIFT: n_entry.kind = mtg_pkg::K_SHIFT;
            mtg_pkg::REQ_MOD:   n_entry.kind = (i_bound == 31'd0) ? mtg_pkg::K_BAD
                                                                  : mtg_pkg::K_MOD;
            default:            n_entry.kind = mtg_pkg::K_RAW;
        endcase
    end

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_req   = r_q[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

`ifndef ASSERT_OFF
    a_no_blind_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty request queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("request queue count out of range");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("request queue pointers disagree with count");
`endif

endmodule

// ----- design/mtg_div.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nothing outside this file.
module mtg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_done,
    output logic [30:0] o_rem
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_dvd;
    logic [30:0] r_rem;
    logic [30:0] r_dvs;
    logic [31:0] trial;
    logic        ge;
    logic [30:0] n_rem;

    assign trial = {r_rem, r_dvd[31]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign n_rem = ge ? 31'(trial - {1'b0, r_dvs}) : trial[30:0];
    assign o_done = r_done;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= 31'd0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_rem < r_dvs)) else $error("remainder not below divisor");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_done) |-> $past(r_busy)) else $error("done without work");
`endif

endmodule

// ----- design/mtg_core.sv -----
// Back end: state memory, seeding, in-place twist, tempering and request forms.
// Depends on mtg_pkg and mtg_div.
module mtg_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [31:0]   i_cfg_wdata,
    input  logic          i_req_valid,
    input  mtg_pkg::t_req i_req,
    output logic          o_req_pop,
    input  logic          i_out_free,
    output logic          o_res_valid,
    output mtg_pkg::t_res o_res
);

    mtg_pkg::t_core_state r_state;
    mtg_pkg::t_core_state n_state;

    logic [31:0] r_mem [624];
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic [31:0] r_seed;
    logic [31:0] r_prev;
    logic [31:0] r_y;
    logic [9:0]  r_cnt;
    logic [9:0]  r_idx;

    logic        mem_we;
    logic [9:0]  waddr;
    logic [31:0] wdata;
    logic [9:0]  addr_a;
    logic [9:0]  addr_b;
    logic [9:0]  nxt;
    logic [9:0]  far;
    logic [31:0] seed_word;
    logic [31:0] twist_word;
    logic [31:0] tempered;
    logic        div_start;
    logic        div_done;
    logic [30:0] div_rem;

    assign nxt = (r_cnt == mtg_pkg::LAST_WORD) ? 10'd0 : r_cnt + 10'd1;
    assign far = (r_cnt < mtg_pkg::TWIST_WRAP) ? r_cnt + mtg_pkg::TWIST_OFF
                                               : r_cnt - mtg_pkg::TWIST_WRAP;
    assign seed_word = (r_cnt == 10'd0) ? r_seed
                     : 32'(mtg_pkg::SEED_MULT * (r_prev ^ (r_prev >> 30))) + {22'd0, r_cnt};
    assign twist_word = r_rd_b ^ (r_y >> 1) ^ (r_y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
    assign tempered = mtg_pkg::temper(r_rd_a);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mtg_pkg::S_SEED:   if (r_cnt == mtg_pkg::LAST_WORD) n_state = mtg_pkg::S_IDLE;
            mtg_pkg::S_IDLE: begin
                if (i_req_valid && i_out_free) begin
                    n_state = (r_idx == mtg_pkg::N_WORDS) ? mtg_pkg::S_TW_A
                                                          : mtg_pkg::S_DRAW_A;
                end
            end
            mtg_pkg::S_TW_A:   n_state = mtg_pkg::S_TW_B;
            mtg_pkg::S_TW_B:   n_state = mtg_pkg::S_TW_C;
            mtg_pkg::S_TW_C:   n_state = (r_cnt == mtg_pkg::LAST_WORD) ? mtg_pkg::S_DRAW_A
                                                                       : mtg_pkg::S_TW_A;
            mtg_pkg::S_DRAW_A: n_state = mtg_pkg::S_DRAW_B;
            mtg_pkg::S_DRAW_B: n_state = (i_req.kind == mtg_pkg::K_MOD) ? mtg_pkg::S_DIV
                                                                        : mtg_pkg::S_IDLE;
            mtg_pkg::S_DIV:    if (div_done) n_state = mtg_pkg::S_IDLE;
            default:           n_state = mtg_pkg::S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = mtg_pkg::S_SEED;
        end
    end

    always_comb begin
        mem_we      = 1'b0;
        waddr       = r_cnt;
        wdata       = seed_word;
        addr_a      = r_cnt;
        addr_b      = nxt;
        o_req_pop   = 1'b0;
        o_res_valid = 1'b0;
        o_res.value = tempered;
        o_res.bad   = 1'b0;
        div_start   = 1'b0;
        unique case (r_state)
            mtg_pkg::S_SEED:   mem_we = 1'b1;
            mtg_pkg::S_TW_B:   addr_b = far;
            mtg_pkg::S_TW_C: begin
                mem_we = 1'b1;
                wdata  = twist_word;
            end
            mtg_pkg::S_DRAW_A: addr_a = r_idx;
            mtg_pkg::S_DRAW_B: begin
                case (i_req.kind)
                    mtg_pkg::K_MOD:   div_start = 1'b1;
                    mtg_pkg::K_SHIFT: o_res.value = tempered >> 1;
                    mtg_pkg::K_BAD: begin
                        o_res.value = 32'd0;
                        o_res.bad   = 1'b1;
                    end
                    default:          o_res.value = tempered;
                endcase
                o_res_valid = (i_req.kind != mtg_pkg::K_MOD);
                o_req_pop   = (i_req.kind != mtg_pkg::K_MOD);
            end
            mtg_pkg::S_DIV: begin
                o_res.value = {1'b0, div_rem};
                o_res_valid = div_done;
                o_req_pop   = div_done;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mtg_pkg::S_SEED) begin
            r_prev <= seed_word;
        end
        if (r_state == mtg_pkg::S_TW_B) begin
            r_y <= {r_rd_a[31], r_rd_b[30:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtg_pkg::S_SEED;
            r_seed  <= mtg_pkg::RESET_SEED;
            r_cnt   <= 10'd0;
            r_idx   <= mtg_pkg::N_WORDS;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
                r_cnt  <= 10'd0;
                r_idx  <= mtg_pkg::N_WORDS;
            end else begin
                unique case (r_state)
                    mtg_pkg::S_SEED: r_cnt <= (r_cnt == mtg_pkg::LAST_WORD) ? 10'd0
                                                                            : r_cnt + 10'd1;
                    mtg_pkg::S_IDLE: r_cnt <= 10'd0;
                    mtg_pkg::S_TW_C: begin
                        if (r_cnt == mtg_pkg::LAST_WORD) begin
                            r_cnt <= 10'd0;
                            r_idx <= 10'd0;
                        end else begin
                            r_cnt <= r_cnt + 10'd1;
                        end
                    end
                    mtg_pkg::S_DRAW_B: r_idx <= r_idx + 10'd1;
                    default: begin
                    end
                endcase
            end
        end
    end

    mtg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (tempered),
        .i_divisor  (i_req.bound),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

`ifndef ASSERT_OFF
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= mtg_pkg::N_WORDS) else $error("word index out of range");
    a_draw_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_DRAW_A) |-> (r_idx < mtg_pkg::N_WORDS))
        else $error("draw without a fresh word");
    a_twist_resets_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtg_pkg::S_TW_C && r_cnt == mtg_pkg::LAST_WORD && !i_cfg_we)
        |=> (r_idx == 10'd0)) else $error("twist did not restart index");
    a_pop_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_pop == o_res_valid) else $error("request retired without result");
`endif

endmodule

// ----- design/mersenne_twister_generator_top.sv -----
// Top level of the MT19937 generator: request queue, core and result register.
// Depends on mtg_pkg, mtg_front and mtg_core.
//
//   channel   handshake            fields
//   request   push / full          i_req_type, i_bound
//   result    empty / pop          o_value, o_bad_bound
//   seed      i_cfg_we             i_cfg_wdata
//
// Raw, shifted and zero-bound requests pass through core states DRAW_A and DRAW_B;
// modulo requests then wait in S_DIV for the remainder unit.
// Every 624th draw first runs the in-place twist, states TW_A, TW_B and TW_C for
// each word, bound by the two read ports of the state memory.
// Reset and each seed write run a seeding pass over all 624 words, one word a cycle;
// requests queue up meanwhile. A full result register holds the core.
module mersenne_twister_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_req_type,
    input  logic [30:0] i_bound,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_value,
    output logic        o_bad_bound,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic          req_valid;
    mtg_pkg::t_req req;
    logic          req_pop;
    logic          res_valid;
    mtg_pkg::t_res res;
    logic          r_out_valid;
    mtg_pkg::t_res r_out;

    mtg_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_req_type (i_req_type),
        .i_bound    (i_bound),
        .o_full     (full),
        .o_valid    (req_valid),
        .o_req      (req),
        .i_pop      (req_pop)
    );

    mtg_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_req_pop   (req_pop),
        .i_out_free  (!r_out_valid),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    assign empty       = !r_out_valid;
    assign o_value     = r_out.value;
    assign o_bad_bound = r_out.bad;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> !r_out_valid) else $error("result register overwritten");
    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_bad_bound) |-> (o_value == 32'd0)) else $error("bad bound with value");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_bad_bound)))
        else $error("waiting result changed");
`endif

endmodule
